// ----- src/hkr_pkg.sv -----
// Package for the HID keyboard report event tracker: payload types, codes and usage table.
package hkr_pkg;

    localparam int REPORT_KEYS = 6;
    localparam int MAX_EVENTS  = 12;
    localparam int KEY_W       = 9;
    localparam int CNT_W       = 16;

    localparam logic [7:0]       LAST_USAGE = 8'h73;
    localparam logic [KEY_W-1:0] KEY_CAPS   = 9'd280;
    localparam logic [KEY_W-1:0] KEY_NUM    = 9'd282;

    localparam logic [0:0] REG_REPEAT_DELAY    = 1'b0;
    localparam logic [0:0] REG_REPEAT_INTERVAL = 1'b1;

    localparam logic [15:0] RESET_DELAY    = 16'd64;
    localparam logic [15:0] RESET_INTERVAL = 16'd4;

    typedef enum logic [1:0] {
        ACT_PRESS   = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_REPEAT  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_LOCKS,
        ST_REPEAT,
        ST_RELEASE,
        ST_PRESS,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [7:0] report_modifiers;
        logic [7:0] usage_0;
        logic [7:0] usage_1;
        logic [7:0] usage_2;
        logic [7:0] usage_3;
        logic [7:0] usage_4;
        logic [7:0] usage_5;
    } report_t;

    typedef struct packed {
        logic [8:0] event_key;
        logic [1:0] event_action;
        logic [5:0] event_modifiers;
        logic       last_event;
    } event_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] hold_count;
        logic [CNT_W-1:0] repeat_phase;
    } slot_t;

    typedef logic [REPORT_KEYS-1:0][KEY_W-1:0] key_vec_t;

    localparam logic [KEY_W-1:0] USAGE_MAP [116] = '{
        9'd0, 9'd0, 9'd0, 9'd0,
        9'd65, 9'd66, 9'd67, 9'd68, 9'd69, 9'd70, 9'd71, 9'd72, 9'd73, 9'd74, 9'd75,
        9'd76, 9'd77, 9'd78, 9'd79, 9'd80, 9'd81, 9'd82, 9'd83, 9'd84, 9'd85, 9'd86,
        9'd87, 9'd88, 9'd89, 9'd90,
        9'd49, 9'd50, 9'd51, 9'd52, 9'd53, 9'd54, 9'd55, 9'd56, 9'd57, 9'd48,
        9'd257, 9'd256, 9'd259, 9'd258, 9'd32, 9'd45, 9'd61, 9'd91, 9'd93, 9'd92,
        9'd0, 9'd59, 9'd39, 9'd96, 9'd44, 9'd46, 9'd47,
        9'd280,
        9'd290, 9'd291, 9'd292, 9'd293, 9'd294, 9'd295, 9'd296, 9'd297, 9'd298,
        9'd299, 9'd300, 9'd301,
        9'd283, 9'd281, 9'd284, 9'd260, 9'd268, 9'd266, 9'd261, 9'd269, 9'd267,
        9'd262, 9'd263, 9'd264, 9'd265,
        9'd282, 9'd331, 9'd332, 9'd333, 9'd334, 9'd335,
        9'd321, 9'd322, 9'd323, 9'd324, 9'd325, 9'd326, 9'd327, 9'd328, 9'd329,
        9'd320, 9'd330,
        9'd0, 9'd348, 9'd0, 9'd336,
        9'd302, 9'd303, 9'd304, 9'd305, 9'd306, 9'd307, 9'd308, 9'd309, 9'd310,
        9'd311, 9'd312, 9'd313
    };

    function automatic logic [KEY_W-1:0] translate(input logic [7:0] usage);
        logic [KEY_W-1:0] key;
        key = '0;
        if (usage <= LAST_USAGE)
        begin
            key = USAGE_MAP[usage[6:0]];
        end
        return key;
    endfunction

endpackage

// ----- src/hkr_translate.sv -----
// Translates the six usage codes of a report into key numbers through the usage table.
module hkr_translate
    import hkr_pkg::*;
(
    input  report_t  report,
    output key_vec_t keys
);

    assign keys[0] = translate(report.usage_0);
    assign keys[1] = translate(report.usage_1);
    assign keys[2] = translate(report.usage_2);
    assign keys[3] = translate(report.usage_3);
    assign keys[4] = translate(report.usage_4);
    assign keys[5] = translate(report.usage_5);

endmodule

// ----- src/hid_keyboard_report_event_tracker.sv -----
// Top level: HID keyboard report event tracker with a slot cache and typematic repeat.
// Per report, the sequencer visits each cache slot once for matching, once for repeat and
// once for release, then each of the six usages for presses, one step per cycle; the repeat,
// release and press steps wait while an output stall holds the pending event.
// Each event is held back until the next one is formed, or until the report is finished,
// and then leaves through an output register; a new report is taken only once the
// previous one has finished. Reset clears the cache and flags and loads a repeat delay
// of 64 and an interval of 4.
module hid_keyboard_report_event_tracker
    import hkr_pkg::*;
#(
    parameter int CACHE_DEPTH = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  report_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output event_t      out_data,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CW = $clog2(CACHE_DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_DEPTH - 1);

    state_t state_reg, state_next;
    slot_t  slots_reg [CACHE_DEPTH];
    slot_t  slots_next [CACHE_DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [5:0]    flags_reg, flags_next;
    logic [15:0]   delay_reg, interval_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [2:0]    pidx_reg, pidx_next;
    logic [CACHE_DEPTH-1:0] held_reg, held_next;
    logic [REPORT_KEYS-1:0] used_reg, used_next;
    logic [REPORT_KEYS-1:0] press_reg, press_next;
    key_vec_t keys_reg, keys_next, keys_in;
    logic [3:0] nev_reg, nev_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0] pend_key_reg, pend_key_next;
    action_t          pend_act_reg, pend_act_next;
    logic   out_valid_reg, out_valid_next;
    event_t out_data_reg, out_data_next;

    logic             stall;
    logic             emit_req;
    logic [KEY_W-1:0] emit_key;
    action_t          emit_act;
    logic             in_range;
    slot_t            cur;

    hkr_translate u_translate (
        .report (in_data),
        .keys   (keys_in)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign stall    = pend_valid_reg && out_valid_reg && !out_ready;
    assign in_range = (CW'(idx_reg) < cnt_reg);
    assign cur      = slots_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= RESET_DELAY;
            interval_reg <= RESET_INTERVAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REPEAT_DELAY:    delay_reg    <= cfg_data;
                REG_REPEAT_INTERVAL: interval_reg <= cfg_data;
                default:             delay_reg    <= delay_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            for (int k = 0; k < CACHE_DEPTH; k++)
            begin
                slots_reg[k] <= '0;
            end
            count_reg      <= '0;
            cnt_reg        <= '0;
            flags_reg      <= '0;
            idx_reg        <= '0;
            pidx_reg       <= '0;
            held_reg       <= '0;
            used_reg       <= '0;
            press_reg      <= '0;
            nev_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slots_reg      <= slots_next;
            count_reg      <= count_next;
            cnt_reg        <= cnt_next;
            flags_reg      <= flags_next;
            idx_reg        <= idx_next;
            pidx_reg       <= pidx_next;
            held_reg       <= held_next;
            used_reg       <= used_next;
            press_reg      <= press_next;
            nev_reg        <= nev_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        keys_reg     <= keys_next;
        pend_key_reg <= pend_key_next;
        pend_act_reg <= pend_act_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        logic caps_t;
        logic num_t;
        logic raw;
        state_next      = state_reg;
        slots_next      = slots_reg;
        count_next      = count_reg;
        cnt_next        = cnt_reg;
        flags_next      = flags_reg;
        idx_next        = idx_reg;
        pidx_next       = pidx_reg;
        held_next       = held_reg;
        used_next       = used_reg;
        press_next      = press_reg;
        keys_next       = keys_reg;
        nev_next        = nev_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_act_next   = pend_act_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        emit_req        = 1'b0;
        emit_key        = '0;
        emit_act        = ACT_PRESS;
        caps_t          = 1'b0;
        num_t           = 1'b0;
        raw             = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    keys_next  = keys_in;
                    flags_next = {flags_reg[5:4],
                                  |(in_data.report_modifiers & 8'h88),
                                  |(in_data.report_modifiers & 8'h44),
                                  |(in_data.report_modifiers & 8'h11),
                                  |(in_data.report_modifiers & 8'h22)};
                    cnt_next   = count_reg;
                    held_next  = '0;
                    used_next  = '0;
                    nev_next   = '0;
                    idx_next   = '0;
                    state_next = ST_MATCH;
                end
            end

            ST_MATCH:
            begin
                // Each slot takes the first usage with its key; a usage may be claimed twice.
                if (in_range)
                begin
                    for (int j = REPORT_KEYS - 1; j >= 0; j--)
                    begin
                        if (keys_reg[j] != '0 && keys_reg[j] == cur.key)
                        begin
                            raw = 1'b1;
                        end
                    end
                    for (int j = 0; j < REPORT_KEYS; j++)
                    begin
                        if (keys_reg[j] != '0 && keys_reg[j] == cur.key && !caps_t)
                        begin
                            used_next[j] = 1'b1;
                            caps_t       = 1'b1;
                        end
                    end
                    held_next[idx_reg] = raw;
                end
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_LOCKS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_LOCKS:
            begin
                for (int j = 0; j < REPORT_KEYS; j++)
                begin
                    press_next[j] = !used_reg[j] && keys_reg[j] != '0 &&
                                    keys_reg[j] != KEY_CAPS && keys_reg[j] != KEY_NUM;
                    if (!used_reg[j] && keys_reg[j] == KEY_CAPS)
                    begin
                        caps_t = !caps_t;
                    end
                    if (!used_reg[j] && keys_reg[j] == KEY_NUM)
                    begin
                        num_t = !num_t;
                    end
                end
                flags_next = flags_reg ^ {num_t, caps_t, 4'b0000};
                idx_next   = '0;
                state_next = ST_REPEAT;
            end

            ST_REPEAT:
            begin
                if (!stall)
                begin
                    if (in_range && held_reg[idx_reg])
                    begin
                        if (cur.hold_count >= delay_reg)
                        begin
                            if (cur.repeat_phase >= interval_reg)
                            begin
                                slots_next[idx_reg].repeat_phase = '0;
                                emit_req = 1'b1;
                                emit_key = cur.key;
                                emit_act = ACT_REPEAT;
                            end
                            else
                            begin
                                slots_next[idx_reg].repeat_phase = cur.repeat_phase + 1'b1;
                            end
                        end
                        else
                        begin
                            slots_next[idx_reg].hold_count = cur.hold_count + 1'b1;
                        end
                    end
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_RELEASE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end

            ST_RELEASE:
            begin
                // Slots are walked from the top down so that compaction only moves
                // slots that have already been visited.
                if (!stall)
                begin
                    if (in_range && !held_reg[idx_reg])
                    begin
                        emit_req = 1'b1;
                        emit_key = cur.key;
                        emit_act = ACT_RELEASE;
                        for (int k = 0; k < CACHE_DEPTH; k++)
                        begin
                            if (k >= int'(idx_reg))
                            begin
                                if (k + 1 < CACHE_DEPTH)
                                begin
                                    slots_next[k] = slots_reg[(k + 1) % CACHE_DEPTH];
                                end
                                else
                                begin
                                    slots_next[k] = '0;
                                end
                            end
                        end
                        count_next = count_reg - 1'b1;
                    end
                    if (idx_reg == '0)
                    begin
                        pidx_next  = '0;
                        state_next = ST_PRESS;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end

            ST_PRESS:
            begin
                if (!stall)
                begin
                    if (press_reg[pidx_reg])
                    begin
                        emit_req = 1'b1;
                        emit_key = keys_reg[pidx_reg];
                        emit_act = ACT_PRESS;
                        if (count_reg < CW'(CACHE_DEPTH))
                        begin
                            slots_next[count_reg[IW-1:0]].key          = keys_reg[pidx_reg];
                            slots_next[count_reg[IW-1:0]].hold_count   = '0;
                            slots_next[count_reg[IW-1:0]].repeat_phase = '0;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    if (pidx_reg == 3'(REPORT_KEYS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        pidx_next = pidx_reg + 1'b1;
                    end
                end
            end

            ST_FLUSH:
            begin
                // The held-back event is the final one of the report.
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = '{pend_key_reg, pend_act_reg, flags_reg, 1'b1};
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // One event is held back so that the last of a report can be marked.
        if (emit_req && nev_reg < 4'(MAX_EVENTS))
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_data_next  = '{pend_key_reg, pend_act_reg, flags_reg, 1'b0};
            end
            pend_valid_next = 1'b1;
            pend_key_next   = emit_key;
            pend_act_next   = emit_act;
            nev_next        = nev_reg + 1'b1;
        end
    end

endmodule
